/* rtl/dtq_pkg.sv */
package dtq_pkg;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_WALK  = 5'b00010,
		ST_CHECK = 5'b00100,
		ST_PLACE = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

endpackage

/* rtl/dtq_ram.sv */
module dtq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/delta_timer_queue.sv */
// Bounded delta-list timer queue. Entries live in a circular buffer held in one
// synchronous RAM (id and delta side by side); a head pointer and a count are
// kept in flip-flops. An insert walks the list from the head, one RAM read and
// one compare per entry, past each entry with a delta not above the remaining
// time. It then opens a gap by shifting the entries behind the slot up one at a
// time, and rewrites the successor's delta when any entry was moved. The block
// returns to idle in the cycle after the result beat is taken, and the input is
// stalled while an item is at work or its result is unclaimed.
module delta_timer_queue #(
	parameter int DEPTH     = 16,
	parameter int TIME_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [15:0] thread_id,
	input  logic [15:0] wait_time,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] removed_id,
	output logic [15:0] head_delta,
	output logic        was_empty,
	output logic        insert_dropped,
	output logic [4:0]  occupancy
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int MW = 16 + TIME_BITS;

	dtq_pkg::state_t state_q;
	logic [AW-1:0]        head_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        pos_q;
	logic [CW-1:0]        mv_q;
	logic                 op_q;
	logic [15:0]          id_q;
	logic [TIME_BITS-1:0] t_q;
	logic                 rd_pend_q;
	logic                 shift_q;
	logic                 adj_q;

	logic                 we;
	logic [AW-1:0]        waddr, raddr;
	logic [MW-1:0]        wdata, rdata;
	logic [TIME_BITS-1:0] rd_delta;

	assign rd_delta = rdata[TIME_BITS-1:0];
	assign in_stall = (state_q != dtq_pkg::ST_IDLE);

	dtq_ram #(.WIDTH(MW), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] i);
		logic [CW:0] s;
		s = {1'b0, h} + {1'b0, i};
		if (s >= (CW+1)'(DEPTH)) begin
			s = s - (CW+1)'(DEPTH);
		end
		return s[AW-1:0];
	endfunction

	// Read address and write control.
	always_comb begin
		raddr = slot(head_q, pos_q);
		we    = 1'b0;
		waddr = slot(head_q, pos_q);
		wdata = {id_q, t_q};
		case (state_q)
			dtq_pkg::ST_PLACE: begin
				if (shift_q) begin
					raddr = slot(head_q, mv_q - CW'(1));
					if (rd_pend_q) begin
						we    = 1'b1;
						waddr = slot(head_q, mv_q);
						wdata = rdata;
					end
				end else if (adj_q) begin
					we    = rd_pend_q;
					waddr = slot(head_q, pos_q + CW'(1));
					wdata = {rdata[MW-1:TIME_BITS], rd_delta - t_q};
				end else begin
					we = 1'b1;
				end
			end
			dtq_pkg::ST_IDLE, dtq_pkg::ST_DONE: raddr = head_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= dtq_pkg::ST_IDLE;
			head_q         <= '0;
			count_q        <= '0;
			out_valid      <= 1'b0;
			rd_pend_q      <= 1'b0;
			shift_q        <= 1'b0;
			adj_q          <= 1'b0;
			pos_q          <= '0;
			mv_q           <= '0;
		end else begin
			case (state_q)
				dtq_pkg::ST_IDLE: begin
					if (in_valid) begin
						op_q      <= op;
						id_q      <= thread_id;
						t_q       <= TIME_BITS'(wait_time);
						pos_q     <= '0;
						rd_pend_q <= 1'b0;
						removed_id     <= '0;
						was_empty      <= 1'b0;
						insert_dropped <= 1'b0;
						state_q   <= dtq_pkg::ST_WALK;
					end
				end
				dtq_pkg::ST_WALK: begin
					// Read for pos was issued in the accepting cycle (head) or in CHECK; data is valid now.
					if (dtq_pkg::op_t'(op_q) == dtq_pkg::OP_REMOVE) begin
						if (count_q == '0) begin
							was_empty <= 1'b1;
						end else begin
							removed_id <= rdata[MW-1:TIME_BITS];
							head_q     <= slot(head_q, CW'(1));
							count_q    <= count_q - CW'(1);
						end
						state_q <= dtq_pkg::ST_DONE;
					end else if (count_q == CW'(DEPTH)) begin
						insert_dropped <= 1'b1;
						state_q        <= dtq_pkg::ST_DONE;
					end else if (pos_q < count_q && t_q >= rd_delta) begin
						t_q     <= t_q - rd_delta;
						pos_q   <= pos_q + CW'(1);
						state_q <= dtq_pkg::ST_CHECK;
					end else begin
						mv_q      <= count_q;
						shift_q   <= (count_q != pos_q);
						adj_q     <= (count_q != pos_q);
						rd_pend_q <= 1'b0;
						state_q   <= dtq_pkg::ST_PLACE;
					end
				end
				dtq_pkg::ST_CHECK: begin
					// Read for the new position was issued this cycle.
					state_q <= dtq_pkg::ST_WALK;
				end
				dtq_pkg::ST_PLACE: begin
					if (shift_q) begin
						if (rd_pend_q) begin
							rd_pend_q <= 1'b0;
							mv_q      <= mv_q - CW'(1);
							if (mv_q - CW'(1) == pos_q) begin
								shift_q <= 1'b0;
							end
						end else begin
							rd_pend_q <= 1'b1;
						end
					end else if (adj_q) begin
						// The successor's old copy still sits at pos; read it there
						// and rewrite it one slot up.
						if (rd_pend_q) begin
							adj_q     <= 1'b0;
							rd_pend_q <= 1'b0;
						end else begin
							rd_pend_q <= 1'b1;
						end
					end else begin
						count_q <= count_q + CW'(1);
						state_q <= dtq_pkg::ST_DONE;
					end
				end
				dtq_pkg::ST_DONE: begin
					// Hold off the result until the head read reflects the final state.
					if (!out_valid && !rd_pend_q) begin
						rd_pend_q <= 1'b1;
					end else if (!out_valid) begin
						out_valid <= 1'b1;
						head_delta <= (count_q == '0) ? 16'd0 : 16'(rd_delta);
						occupancy <= 5'(count_q);
					end else if (!out_stall) begin
						out_valid <= 1'b0;
						rd_pend_q <= 1'b0;
						state_q   <= dtq_pkg::ST_IDLE;
					end
				end
				default: state_q <= dtq_pkg::ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(DEPTH))
		else $error("count exceeds depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == dtq_pkg::ST_DONE)
		else $error("result outside done state");
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> !out_valid)
		else $error("result raised at accept");

endmodule
